// File: hdl/adsr_pkg.sv
package adsr_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int CORDIC_STEPS = 16;
  localparam int BLEP_STEPS = 30;

  localparam logic [2:0] REG_PHASE_STEP = 3'd0;
  localparam logic [2:0] REG_WAVEFORM   = 3'd1;
  localparam logic [2:0] REG_ATTACK     = 3'd2;
  localparam logic [2:0] REG_DECAY      = 3'd3;
  localparam logic [2:0] REG_SUSTAIN    = 3'd4;
  localparam logic [2:0] REG_RELEASE    = 3'd5;
  localparam logic [2:0] REG_NOTE       = 3'd6;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;

  localparam logic [15:0] FULL_Q15 = 16'h8000;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [14:0] SCALE_OUT = 15'd32000;

  localparam logic signed [33:0] ATAN_TURNS [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
    34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861
  };

  typedef struct packed {
    logic [23:0]        sample_index;
    logic signed [15:0] noise_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               last_of_note;
  } out_t;

endpackage

// File: hdl/adsr_tone_oscillator_top.sv
// Enveloped tone generator: one 16-bit sample per accepted word, sine (table
// angle plus CORDIC), PolyBLEP square and saw, triangle or external noise,
// shaped by a linear ADSR envelope. A new word is taken every clock while the
// result side takes results. The PolyBLEP windows are computed by 30-stage
// restoring dividers (the CORDIC and the envelope divider run alongside them
// in the same stages). The whole pipeline holds while a result waits. The
// user must write configuration through cfg_we/cfg_index/cfg_wdata only while
// no word is in flight; the block itself does not enforce this.
module adsr_tone_oscillator_top
  import adsr_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  localparam logic [31:0] KEEP = ~32'd0 << (32 - SINE_TABLE_BITS);

  typedef enum logic [4:0] {
    SEG_ATT  = 5'b00001,
    SEG_DEC  = 5'b00010,
    SEG_SUS  = 5'b00100,
    SEG_REL  = 5'b01000,
    SEG_ZERO = 5'b10000
  } seg_t;

  typedef struct packed {
    logic               neg0;
    logic               pos0;
    logic [30:0]        rem0;
    logic [29:0]        q0;
    logic               neg1;
    logic               pos1;
    logic [30:0]        rem1;
    logic [29:0]        q1;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic               flip;
    logic [23:0]        erem;
    logic [15:0]        elo;
    logic [15:0]        eq;
    seg_t               seg;
    logic signed [33:0] base;
    logic               last;
  } dst_t;

  // configuration
  logic [30:0] phase_step_r;
  logic [2:0]  waveform_r;
  logic [23:0] attack_r, decay_r, release_r, note_r;
  logic [15:0] sustain_r;
  logic [15:0] s_cl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= 31'd42852281;
      waveform_r   <= WAVE_SINE;
      attack_r     <= 24'd441;
      decay_r      <= 24'd0;
      sustain_r    <= FULL_Q15;
      release_r    <= 24'd441;
      note_r       <= 24'd22050;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP: phase_step_r <= cfg_wdata;
        REG_WAVEFORM:   waveform_r   <= cfg_wdata[2:0];
        REG_ATTACK:     attack_r     <= cfg_wdata[23:0];
        REG_DECAY:      decay_r      <= cfg_wdata[23:0];
        REG_SUSTAIN:    sustain_r    <= cfg_wdata[15:0];
        REG_RELEASE:    release_r    <= cfg_wdata[23:0];
        REG_NOTE:       note_r       <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign s_cl = (sustain_r > FULL_Q15) ? FULL_Q15 : sustain_r;

  logic en;
  logic out_valid_r;
  out_t out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en && rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stage 1: input word
  logic        v1_r;
  logic [23:0] idx1_r;
  logic signed [15:0] noise1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r   <= in_data.sample_index;
      noise1_r <= in_data.noise_value;
    end
  end

  // stage 1 -> 2: phase product and envelope segment
  logic [54:0] ph_full;
  logic signed [24:0] rel_start;
  logic [24:0] ad_sum;
  logic signed [25:0] k_rel;
  seg_t  seg_nxt;
  logic [15:0] ma_nxt;
  logic [23:0] mb_nxt;
  logic last_nxt;

  assign ph_full   = 55'(idx1_r) * 55'(phase_step_r);
  assign rel_start = $signed({1'b0, note_r}) - $signed({1'b0, release_r});
  assign ad_sum    = {1'b0, attack_r} + {1'b0, decay_r};
  assign k_rel     = $signed({2'b00, idx1_r}) - $signed({rel_start[24], rel_start});
  assign last_nxt  = (({1'b0, idx1_r}) + 25'd1) == {1'b0, note_r};

  always_comb begin
    seg_nxt = SEG_ZERO;
    ma_nxt  = 16'd0;
    mb_nxt  = 24'd0;
    priority if (idx1_r < attack_r) begin
      seg_nxt = SEG_ATT;
      ma_nxt  = FULL_Q15;
      mb_nxt  = idx1_r;
    end else if ({1'b0, idx1_r} < ad_sum) begin
      seg_nxt = SEG_DEC;
      ma_nxt  = FULL_Q15 - s_cl;
      mb_nxt  = idx1_r - attack_r;
    end else if ($signed({1'b0, idx1_r}) < rel_start) begin
      seg_nxt = SEG_SUS;
    end else if (release_r == 24'd0 || k_rel >= $signed({2'b00, release_r})) begin
      seg_nxt = SEG_ZERO;
    end else begin
      seg_nxt = SEG_REL;
      ma_nxt  = s_cl;
      mb_nxt  = release_r - k_rel[23:0];
    end
  end

  logic        v2_r;
  logic [31:0] ph2_r;
  seg_t        seg2_r;
  logic [15:0] ma2_r;
  logic [23:0] mb2_r;
  logic        last2_r;
  logic signed [15:0] noise2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph2_r    <= ph_full[31:0];
      seg2_r   <= seg_nxt;
      ma2_r    <= ma_nxt;
      mb2_r    <= mb_nxt;
      last2_r  <= last_nxt;
      noise2_r <= noise1_r;
    end
  end

  // stage 2 -> divider entry
  dst_t d0_nxt;
  logic [32:0] x0_33, x1_33, p_33, top_p;
  logic [31:0] ph_half;
  logic [31:0] sq_angle;
  logic signed [33:0] z_raw;
  logic [39:0] env_num;

  assign p_33     = {2'b00, phase_step_r};
  assign top_p    = 33'h1_0000_0000 - p_33;
  assign ph_half  = ph2_r + 32'h8000_0000;
  assign x0_33    = {1'b0, ph2_r};
  assign x1_33    = {1'b0, ph_half};
  assign sq_angle = ph2_r & KEEP;
  assign z_raw    = {{2{sq_angle[31]}}, sq_angle};
  assign env_num  = 40'(ma2_r) * 40'(mb2_r);

  always_comb begin
    d0_nxt = '0;
    if (x0_33 < p_33) begin
      d0_nxt.neg0 = 1'b1;
      d0_nxt.rem0 = ph2_r[30:0];
    end else if (x0_33 > top_p) begin
      d0_nxt.pos0 = 1'b1;
      d0_nxt.rem0 = 31'(33'h1_0000_0000 - x0_33);
    end
    if (x1_33 < p_33) begin
      d0_nxt.neg1 = 1'b1;
      d0_nxt.rem1 = ph_half[30:0];
    end else if (x1_33 > top_p) begin
      d0_nxt.pos1 = 1'b1;
      d0_nxt.rem1 = 31'(33'h1_0000_0000 - x1_33);
    end
    d0_nxt.cx = CORDIC_X0;
    d0_nxt.cy = '0;
    if (z_raw > ONE_Q30) begin
      d0_nxt.cz   = z_raw - HALF_TURN;
      d0_nxt.flip = 1'b1;
    end else if (z_raw < -ONE_Q30) begin
      d0_nxt.cz   = z_raw + HALF_TURN;
      d0_nxt.flip = 1'b1;
    end else begin
      d0_nxt.cz   = z_raw;
    end
    d0_nxt.erem = env_num[39:16];
    d0_nxt.elo  = env_num[15:0];
    d0_nxt.seg  = seg2_r;
    d0_nxt.last = last2_r;
    unique case (waveform_r)
      WAVE_SQUARE: d0_nxt.base = ph2_r[31] ? -ONE_Q30 : ONE_Q30;
      WAVE_SAW:    d0_nxt.base = $signed({3'b000, ph2_r[31:1]}) - ONE_Q30;
      WAVE_TRI:    d0_nxt.base = ph2_r[31] ?
                     $signed({2'b00, ph2_r - 32'h8000_0000}) - ONE_Q30 :
                     $signed({2'b00, 32'h8000_0000 - ph2_r}) - ONE_Q30;
      WAVE_NOISE:  d0_nxt.base = 34'(noise2_r) <<< 15;
      default:     d0_nxt.base = '0;
    endcase
  end

  // divider / cordic section
  dst_t d_r [0:BLEP_STEPS];
  logic [BLEP_STEPS:0] dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else if (en) dv_r <= {dv_r[BLEP_STEPS-1:0], v2_r};
  end

  always_ff @(posedge clk) begin
    if (en) d_r[0] <= d0_nxt;
  end

  for (genvar j = 0; j < BLEP_STEPS; j++) begin : g_div
    localparam int JA = (j < CORDIC_STEPS) ? j : 0;
    dst_t cur, nx;
    logic [31:0] r0, r1;
    logic [24:0] re;
    logic [23:0] edv;
    logic signed [33:0] xs, ys;

    assign cur = d_r[j];
    assign r0  = {cur.rem0, 1'b0};
    assign r1  = {cur.rem1, 1'b0};
    assign re  = {cur.erem, cur.elo[15]};
    assign edv = (cur.seg == SEG_ATT) ? attack_r :
                 (cur.seg == SEG_DEC) ? decay_r : release_r;
    assign xs  = cur.cx >>> j;
    assign ys  = cur.cy >>> j;

    always_comb begin
      nx = cur;
      if (r0 >= {1'b0, phase_step_r}) begin
        nx.rem0 = 31'(r0 - {1'b0, phase_step_r});
        nx.q0   = {cur.q0[28:0], 1'b1};
      end else begin
        nx.rem0 = r0[30:0];
        nx.q0   = {cur.q0[28:0], 1'b0};
      end
      if (r1 >= {1'b0, phase_step_r}) begin
        nx.rem1 = 31'(r1 - {1'b0, phase_step_r});
        nx.q1   = {cur.q1[28:0], 1'b1};
      end else begin
        nx.rem1 = r1[30:0];
        nx.q1   = {cur.q1[28:0], 1'b0};
      end
      if (j < CORDIC_STEPS) begin
        if (!cur.cz[33]) begin
          nx.cx = cur.cx - ys;
          nx.cy = cur.cy + xs;
          nx.cz = cur.cz - ATAN_TURNS[JA];
        end else begin
          nx.cx = cur.cx + ys;
          nx.cy = cur.cy - xs;
          nx.cz = cur.cz + ATAN_TURNS[JA];
        end
        nx.elo = {cur.elo[14:0], 1'b0};
        if (re >= {1'b0, edv}) begin
          nx.erem = 24'(re - {1'b0, edv});
          nx.eq   = {cur.eq[14:0], 1'b1};
        end else begin
          nx.erem = re[23:0];
          nx.eq   = {cur.eq[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) d_r[j+1] <= nx;
    end
  end

  // blep squares and envelope value
  dst_t dl;
  logic [30:0] w0, w1;
  logic [61:0] sq0, sq1;
  logic [15:0] env_nxt;

  assign dl  = d_r[BLEP_STEPS];
  assign w0  = 31'h4000_0000 - {1'b0, dl.q0};
  assign w1  = 31'h4000_0000 - {1'b0, dl.q1};
  assign sq0 = 62'(w0) * 62'(w0);
  assign sq1 = 62'(w1) * 62'(w1);

  always_comb begin
    unique case (dl.seg)
      SEG_ATT: env_nxt = dl.eq;
      SEG_DEC: env_nxt = FULL_Q15 - dl.eq;
      SEG_SUS: env_nxt = s_cl;
      SEG_REL: env_nxt = dl.eq;
      default: env_nxt = 16'd0;
    endcase
  end

  logic        va_r;
  logic [30:0] bm0_r, bm1_r;
  logic        neg0_r, pos0_r, neg1_r, pos1_r;
  logic signed [33:0] sy_r, base_r;
  logic        flip_r, lasta_r;
  logic [15:0] env_r;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= dv_r[BLEP_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bm0_r   <= sq0[60:30];
      bm1_r   <= sq1[60:30];
      neg0_r  <= dl.neg0;
      pos0_r  <= dl.pos0;
      neg1_r  <= dl.neg1;
      pos1_r  <= dl.pos1;
      sy_r    <= dl.cy;
      flip_r  <= dl.flip;
      base_r  <= dl.base;
      lasta_r <= dl.last;
      env_r   <= env_nxt;
    end
  end

  // waveform compose
  logic signed [33:0] b0, b1, wave_nxt;

  assign b0 = neg0_r ? -$signed({3'b000, bm0_r}) :
              pos0_r ?  $signed({3'b000, bm0_r}) : 34'sd0;
  assign b1 = neg1_r ? -$signed({3'b000, bm1_r}) :
              pos1_r ?  $signed({3'b000, bm1_r}) : 34'sd0;

  always_comb begin
    unique case (waveform_r)
      WAVE_SINE:   wave_nxt = flip_r ? -sy_r : sy_r;
      WAVE_SQUARE: wave_nxt = base_r + b0 - b1;
      WAVE_SAW:    wave_nxt = base_r - b0;
      WAVE_TRI:    wave_nxt = base_r;
      WAVE_NOISE:  wave_nxt = base_r;
      default:     wave_nxt = '0;
    endcase
  end

  logic        vc_r, lastc_r;
  logic signed [33:0] wave_r;
  logic [15:0] envc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wave_r  <= wave_nxt;
      envc_r  <= env_r;
      lastc_r <= lasta_r;
    end
  end

  // product
  logic        vp_r, lastp_r;
  logic signed [50:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else if (en) vp_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 51'(wave_r) * $signed({35'd0, envc_r});
      lastp_r <= lastc_r;
    end
  end

  // clamp, magnitude, scale partial products
  localparam logic signed [50:0] LIM = 51'sd35184372088832;
  logic [45:0] mag;
  logic        prod_neg;

  assign prod_neg = prod_r[50];
  assign mag = (prod_r > LIM || prod_r < -LIM) ? 46'h2000_0000_0000 :
               prod_neg ? 46'(-prod_r) : 46'(prod_r);

  logic        vm_r, negm_r, lastm_r;
  logic [37:0] phi_r, plo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (en) vm_r <= vp_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r   <= 38'(mag[45:23]) * 38'(SCALE_OUT);
      plo_r   <= 38'(mag[22:0]) * 38'(SCALE_OUT);
      negm_r  <= prod_neg;
      lastm_r <= lastp_r;
    end
  end

  // final sum and sign
  logic [60:0] total;
  logic [15:0] res;

  assign total = {phi_r, 23'd0} + 61'(plo_r);
  assign res   = {1'b0, total[59:45]};

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vm_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.sample_out   <= negm_r ? -$signed(res) : $signed(res);
      out_data_r.last_of_note <= lastm_r;
    end
  end

`ifndef SYNTH
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sample_out <= 16'sd32000 && out_data.sample_out >= -16'sd32000))
    else $error("sample out of range");

  a_blep_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[BLEP_STEPS] && (dl.neg0 || dl.pos0)) |-> (dl.rem0 < phase_step_r))
    else $error("blep remainder not below phase step");

  a_env_max: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> (env_r <= FULL_Q15))
    else $error("envelope above full scale");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_r))
    else $error("pipeline moved during stall");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted word not captured");
`endif

endmodule

// File: verif/adsr_tone_oscillator_top_tb.sv
class tone_scoreboard;
  localparam int TABLE_BITS = 10;
  localparam longint ONE = 64'sd1073741824;
  localparam longint TURN = 64'sd4294967296;
  localparam longint LIM = 64'sd35184372088832;

  longint step, wave_sel, att, dec, sus, rel, note;
  adsr_pkg::out_t pending[$];
  int errors;

  function new();
    step = 42852281; wave_sel = 0; att = 441; dec = 0;
    sus = 32768; rel = 441; note = 22050; errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [30:0] v);
    case (idx)
      adsr_pkg::REG_PHASE_STEP: step = longint'(v);
      adsr_pkg::REG_WAVEFORM:   wave_sel = longint'(v[2:0]);
      adsr_pkg::REG_ATTACK:     att = longint'(v[23:0]);
      adsr_pkg::REG_DECAY:      dec = longint'(v[23:0]);
      adsr_pkg::REG_SUSTAIN:    sus = longint'(v[15:0]);
      adsr_pkg::REG_RELEASE:    rel = longint'(v[23:0]);
      adsr_pkg::REG_NOTE:       note = longint'(v[23:0]);
      default: ;
    endcase
  endfunction

  function longint blep(longint x, longint p);
    longint w;
    if (x < p) begin
      w = ONE - ((x <<< 30) / p);
      return -((w * w) >>> 30);
    end
    if (p > 0 && x > TURN - p) begin
      w = ONE - (((TURN - x) <<< 30) / p);
      return (w * w) >>> 30;
    end
    return 0;
  endfunction

  function longint sine(logic [31:0] ph);
    logic [31:0] q;
    longint z, x, y, nx;
    bit flip;
    q = ph & ~((32'h1 << (32 - TABLE_BITS)) - 1);
    z = q[31] ? longint'(q) - TURN : longint'(q);
    x = adsr_pkg::CORDIC_X0;
    y = 0;
    flip = 0;
    if (z > ONE) begin
      z -= 2 * ONE; flip = 1;
    end else if (z < -ONE) begin
      z += 2 * ONE; flip = 1;
    end
    for (int k = 0; k < 16; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k); y = y + (x >>> k); z -= adsr_pkg::ATAN_TURNS[k];
      end else begin
        nx = x + (y >>> k); y = y - (x >>> k); z += adsr_pkg::ATAN_TURNS[k];
      end
      x = nx;
    end
    return flip ? -y : y;
  endfunction

  function longint envelope(longint i);
    longint s, rs, k;
    s = sus > 32768 ? 32768 : sus;
    rs = note - rel;
    if (i < att) return (i * 32768) / att;
    if (i < att + dec) return 32768 - ((32768 - s) * (i - att)) / dec;
    if (i < rs) return s;
    if (rel == 0) return 0;
    k = i - rs;
    if (k >= rel) return 0;
    return (s * (rel - k)) / rel;
  endfunction

  function void note_word(adsr_pkg::in_t w);
    longint i, ph, wv, prod, mag, res;
    logic [63:0] full;
    adsr_pkg::out_t e;
    i = longint'(w.sample_index);
    full = i * step;
    ph = longint'(full[31:0]);
    case (wave_sel)
      adsr_pkg::WAVE_SINE:   wv = sine(ph[31:0]);
      adsr_pkg::WAVE_SQUARE: wv = (ph < 2 * ONE ? ONE : -ONE) + blep(ph, step)
                                  - blep((ph + 2 * ONE) % TURN, step);
      adsr_pkg::WAVE_SAW:    wv = (ph >>> 1) - ONE - blep(ph, step);
      adsr_pkg::WAVE_TRI:    wv = (ph >= 2 * ONE ? ph - 2 * ONE : 2 * ONE - ph) - ONE;
      adsr_pkg::WAVE_NOISE:  wv = longint'(w.noise_value) * 32768;
      default:               wv = 0;
    endcase
    prod = wv * envelope(i);
    if (prod > LIM) prod = LIM;
    if (prod < -LIM) prod = -LIM;
    mag = prod < 0 ? -prod : prod;
    res = (mag * 32000) >>> 45;
    if (prod < 0) res = -res;
    e.sample_out = res[15:0];
    e.last_of_note = (i + 1 == note);
    pending = {pending, e};
  endfunction

  function void check_word(adsr_pkg::out_t got);
    adsr_pkg::out_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected word %h", got);
      return;
    end
    e = pending.pop_front();
    if (e.sample_out !== got.sample_out || e.last_of_note !== got.last_of_note) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected sample %0d last %0d, got sample %0d last %0d",
                 e.sample_out, e.last_of_note, got.sample_out, got.last_of_note);
    end
  endfunction
endclass

module adsr_tone_oscillator_top_tb;
  import adsr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_wdata = '0;

  tone_scoreboard sb = new();
  longint cycles = 0;
  int out_hold = 0;
  bit steady_in, steady_out;

  adsr_tone_oscillator_top DUT (.*);

  always #1 clk = ~clk;

  function int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("adsr_tone_oscillator_top_tb failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
    if (steady_out) begin
      out_ready <= 1;
    end else if (out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= 0;
    end else begin
      out_hold  <= gap_len();
      out_ready <= 1;
    end
  end

  task send_word(int idx, int nz);
    int g;
    g = steady_in ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data.sample_index <= idx[23:0];
    in_data.noise_value <= nz[15:0];
    do @(posedge clk); while (!in_ready);
    sb.note_word(in_data);
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, int v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v[30:0];
    @(posedge clk);
    sb.write_reg(idx, v[30:0]);
  endtask

  task run_phase(int count);
    int n;
    for (int k = 0; k < count; k++) begin
      n = int'(sb.note);
      if ($urandom_range(0, 9) == 0)
        send_word($urandom, $urandom);
      else
        send_word($urandom_range(0, n + 20), $urandom);
    end
  endtask

  initial begin
    int n, ph;
    steady_in = 0;
    steady_out = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset settings, envelope and note boundaries plus noise extremes
    send_word(0, 'h8000);
    send_word(1, 'h7fff);
    send_word(440, 0);
    send_word(441, 'hffff);
    send_word(21608, 0);
    send_word(21609, 0);
    send_word(22049, 0);
    send_word(22050, 0);
    send_word('hffffff, 'h8000);
    drain();
    for (int w = 1; w < 8; w++) begin
      write_reg(REG_WAVEFORM, w);
      cfg_we <= 0;
      send_word(0, 'h8000);
      send_word(1, 'h7fff);
      send_word(300, 'h1234);
      send_word(22049, 'h8000);
      send_word('hffffff, 'h7fff);
      drain();
    end
    for (ph = 0; ph < 14; ph++) begin
      steady_in = (ph % 4 == 2);
      steady_out = (ph % 5 == 3);
      if (ph == 0) begin
        write_reg(REG_PHASE_STEP, 'h7fffffff);
        write_reg(REG_WAVEFORM, WAVE_SQUARE);
        write_reg(REG_ATTACK, 'hffffff);
        write_reg(REG_DECAY, 'hffffff);
        write_reg(REG_SUSTAIN, 'hffff);
        write_reg(REG_RELEASE, 'hffffff);
        write_reg(REG_NOTE, 'hffffff);
        write_reg(3'd7, $urandom);
      end else if (ph == 1) begin
        write_reg(REG_PHASE_STEP, 0);
        write_reg(REG_WAVEFORM, WAVE_SAW);
        write_reg(REG_ATTACK, 0);
        write_reg(REG_DECAY, 0);
        write_reg(REG_SUSTAIN, 0);
        write_reg(REG_RELEASE, 0);
        write_reg(REG_NOTE, 0);
      end else begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24'hffffff)
                                         : $urandom_range(1, 3000);
        write_reg(REG_PHASE_STEP, ($urandom_range(0, 1) == 0) ? $urandom
                                   : $urandom_range(1, 1 << 22));
        write_reg(REG_WAVEFORM, ph % 8);
        write_reg(REG_ATTACK, $urandom_range(0, n / 3));
        write_reg(REG_DECAY, $urandom_range(0, n / 3));
        write_reg(REG_SUSTAIN, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                : $urandom_range(0, 32768));
        write_reg(REG_RELEASE, ($urandom_range(0, 4) == 0) ? $urandom_range(n, n + 500)
                                : $urandom_range(0, n / 3));
        write_reg(REG_NOTE, n);
      end
      cfg_we <= 0;
      run_phase(ph < 2 ? 50 : 105);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("adsr_tone_oscillator_top_tb passed");
    else
      $display("adsr_tone_oscillator_top_tb failed");
    $finish;
  end
endmodule

// File: files.f
hdl/adsr_pkg.sv
hdl/adsr_tone_oscillator_top.sv
verif/adsr_tone_oscillator_top_tb.sv
